FILE: hw/rtl/phpcc_pkg.sv
// Shared types, codes and helper functions of the packet header parser.
`default_nettype none
package phpcc_pkg;

	// Packet layout
	localparam int unsigned HDR_BYTES  = 36;
	localparam int unsigned CSUM_BYTES = 4;
	localparam int unsigned MIN_BYTES  = HDR_BYTES + CSUM_BYTES;
	localparam int unsigned POS_W      = 17;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	// Result queue, depth a power of two
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = QPTR_W + 1;

	// Result kinds
	localparam logic [3:0] KIND_VERSION   = 4'd0;
	localparam logic [3:0] KIND_PAY_LEN   = 4'd6;
	localparam logic [3:0] KIND_SACK_CNT  = 4'd9;
	localparam logic [3:0] KIND_CONN_ID   = 4'd10;
	localparam logic [3:0] KIND_BLK_START = 4'd11;
	localparam logic [3:0] KIND_BLK_END   = 4'd12;
	localparam logic [3:0] KIND_PAYLOAD   = 4'd13;
	localparam logic [3:0] KIND_VERDICT   = 4'd14;

	// Verdict codes
	localparam logic [2:0] VERDICT_OK        = 3'd0;
	localparam logic [2:0] VERDICT_SHORT     = 3'd1;
	localparam logic [2:0] VERDICT_VERSION   = 3'd2;
	localparam logic [2:0] VERDICT_BLOCKS    = 3'd3;
	localparam logic [2:0] VERDICT_PAY_LONG  = 3'd4;
	localparam logic [2:0] VERDICT_CRC       = 3'd5;

	// Header fault codes
	localparam logic [1:0] FAULT_NONE     = 2'd0;
	localparam logic [1:0] FAULT_VERSION  = 2'd1;
	localparam logic [1:0] FAULT_BLOCKS   = 2'd2;
	localparam logic [1:0] FAULT_PAY_LONG = 2'd3;

	// Register indexes
	localparam logic [1:0] REG_VERSION  = 2'd0;
	localparam logic [1:0] REG_MAX_SACK = 2'd1;
	localparam logic [1:0] REG_MAX_PAY  = 2'd2;

	// CRC-32, reflected
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	typedef struct packed {
		logic [3:0]  kind;
		logic [63:0] value;
		logic [2:0]  code;
		logic        run_end;
	} item_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] kind;
	} field_hit_t;

	// Which header field completes when byte count reaches cnt
	function automatic field_hit_t field_done(input logic [5:0] cnt);
		field_hit_t r;
		r.hit = 1'b1;
		case (cnt)
			6'd1:    r.kind = 4'd0;
			6'd2:    r.kind = 4'd1;
			6'd4:    r.kind = 4'd2;
			6'd8:    r.kind = 4'd3;
			6'd12:   r.kind = 4'd4;
			6'd14:   r.kind = 4'd5;
			6'd16:   r.kind = 4'd6;
			6'd24:   r.kind = 4'd7;
			6'd32:   r.kind = 4'd8;
			6'd34:   r.kind = 4'd9;
			6'd36:   r.kind = 4'd10;
			default: begin
				r.hit  = 1'b0;
				r.kind = 4'd0;
			end
		endcase
		return r;
	endfunction

	// One byte through the CRC, bit at a time
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/packet_header_parser_crc_check.sv
// Packet deframer: header field extraction, SACK words, payload pass-through, CRC-32 check.
//
//  channel | signals                                         | moves
//  --------+-------------------------------------------------+--------------------------
//  byte    | byte_valid/byte_ready, rx_byte, end_of_buffer   | one received byte
//  item    | item_valid/item_ready, item_kind, item_value,   | one field, word, payload
//          | verdict_code, run_end                           | byte or verdict
//  config  | psel, penable, pwrite, paddr, pwdata, prdata    | APB register access
//
// Each byte is decoded in the cycle it is accepted and its results (zero, one or two)
// land in a four-entry result queue, so one byte per cycle is taken while the queue
// has room for two; the queue drains one result per cycle while item_ready is high.
// A flagged byte that completes a field yields two results, the field and then the verdict.
// Reset clears the queue and all packet state and loads the register defaults.
// A stalled item channel fills the queue and then holds byte_ready low.
`default_nettype none
module packet_header_parser_crc_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// byte channel
	input  wire logic        byte_valid,
	output logic             byte_ready,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        end_of_buffer,
	// item channel
	output logic             item_valid,
	input  wire logic        item_ready,
	output logic [3:0]       item_kind,
	output logic [63:0]      item_value,
	output logic [2:0]       verdict_code,
	output logic             run_end,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import phpcc_pkg::*;

	// configuration registers
	logic [7:0]  exp_ver_q;
	logic [7:0]  max_sack_q;
	logic [15:0] max_pay_q;

	// packet state
	logic [POS_W-1:0] pos_q;
	logic [63:0]      shift_q;
	logic [31:0]      crc_q;
	logic [31:0]      csum_q;
	logic [15:0]      blk_cnt_q;
	logic [15:0]      pay_len_q;
	logic [7:0]       ver_q;
	logic [1:0]       fault_q;

	// result queue
	item_t             queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic accept;
	logic pop;

	// next-state and result signals
	logic [POS_W-1:0] pos_next;
	logic [63:0]      shift_next;
	logic [31:0]      crc_next;
	logic [31:0]      csum_next;
	logic [15:0]      blk_cnt_next;
	logic [15:0]      pay_len_next;
	logic [7:0]       ver_next;
	logic [1:0]       fault_next;
	logic             emit;
	logic [3:0]       emit_kind;
	logic [63:0]      emit_value;
	logic [2:0]       code;
	field_hit_t       fhit;
	logic [63:0]      hdr_shift;
	logic [19:0]      sack_end;
	logic [19:0]      csum_end;
	logic [20:0]      pay_end;
	logic [20:0]      expect_len;
	logic [POS_W-1:0] sack_off;
	item_t            res0;
	item_t            res1;
	logic             push0;
	logic             push1;

	assign pready = 1'b1;

	// register read
	always_comb begin
		case (paddr[3:2])
			REG_VERSION:  prdata = {24'd0, exp_ver_q};
			REG_MAX_SACK: prdata = {24'd0, max_sack_q};
			REG_MAX_PAY:  prdata = {16'd0, max_pay_q};
			default:      prdata = 32'd0;
		endcase
	end

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_ver_q  <= 8'd1;
			max_sack_q <= 8'd8;
			max_pay_q  <= 16'd1400;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_VERSION:  exp_ver_q  <= pwdata[7:0];
				REG_MAX_SACK: max_sack_q <= pwdata[7:0];
				REG_MAX_PAY:  max_pay_q  <= pwdata[15:0];
				default:      ;
			endcase
		end
	end

	// handshakes: room for two results before taking a byte
	assign byte_ready = (count_q <= QCNT_W'(QDEPTH - 2));
	assign accept     = byte_valid && byte_ready;
	assign item_valid = (count_q != '0);
	assign pop        = item_valid && item_ready;

	// section boundaries from the held header fields
	assign sack_end   = 20'(HDR_BYTES) + {1'b0, blk_cnt_q, 3'b000};
	assign csum_end   = sack_end + 20'(CSUM_BYTES);
	assign pay_end    = {1'b0, csum_end} + {5'd0, pay_len_q};
	assign sack_off   = pos_q - POS_W'(HDR_BYTES);
	assign fhit       = field_done(pos_q[5:0] + 6'd1);
	assign hdr_shift  = {shift_q[55:0], rx_byte};

	// byte decode
	always_comb begin
		pos_next     = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;
		shift_next   = shift_q;
		crc_next     = crc_q;
		csum_next    = csum_q;
		blk_cnt_next = blk_cnt_q;
		pay_len_next = pay_len_q;
		ver_next     = ver_q;
		fault_next   = fault_q;
		emit         = 1'b0;
		emit_kind    = KIND_PAYLOAD;
		emit_value   = 64'd0;

		if (pos_q < POS_W'(HDR_BYTES)) begin
			// header byte
			crc_next   = crc_byte(crc_q, rx_byte);
			shift_next = hdr_shift;
			if (fhit.hit) begin
				emit       = 1'b1;
				emit_kind  = fhit.kind;
				emit_value = hdr_shift;
				shift_next = 64'd0;
				if (fhit.kind == KIND_VERSION)  ver_next     = hdr_shift[7:0];
				if (fhit.kind == KIND_PAY_LEN)  pay_len_next = hdr_shift[15:0];
				if (fhit.kind == KIND_SACK_CNT) blk_cnt_next = hdr_shift[15:0];
			end
			// header checks once the last header byte is in
			if (fhit.hit && fhit.kind == KIND_CONN_ID) begin
				if (ver_q != exp_ver_q)
					fault_next = FAULT_VERSION;
				else if (blk_cnt_q > {8'd0, max_sack_q})
					fault_next = FAULT_BLOCKS;
				else if (pay_len_q > max_pay_q)
					fault_next = FAULT_PAY_LONG;
				else
					fault_next = FAULT_NONE;
			end
		end else if (fault_q == FAULT_NONE) begin
			if ({3'd0, pos_q} < sack_end) begin
				// SACK start/end words
				crc_next   = crc_byte(crc_q, rx_byte);
				shift_next = {32'd0, shift_q[23:0], rx_byte};
				if (sack_off[1:0] == 2'b11) begin
					emit       = 1'b1;
					emit_kind  = sack_off[2] ? KIND_BLK_END : KIND_BLK_START;
					emit_value = {32'd0, shift_q[23:0], rx_byte};
					shift_next = 64'd0;
				end
			end else if ({3'd0, pos_q} < csum_end) begin
				csum_next = {csum_q[23:0], rx_byte};
			end else if ({4'd0, pos_q} < pay_end) begin
				crc_next   = crc_byte(crc_q, rx_byte);
				emit       = 1'b1;
				emit_kind  = KIND_PAYLOAD;
				emit_value = {56'd0, rx_byte};
			end
		end
	end

	// verdict on the flagged byte
	assign expect_len = 21'(MIN_BYTES) + {2'd0, blk_cnt_next, 3'b000} + {5'd0, pay_len_next};

	always_comb begin
		if (pos_next < POS_W'(MIN_BYTES))
			code = VERDICT_SHORT;
		else if (fault_next != FAULT_NONE)
			code = {1'b0, fault_next} + 3'd1;
		else if ({4'd0, pos_next} < expect_len)
			code = VERDICT_SHORT;
		else if ((crc_next ^ CRC_INIT) != csum_next)
			code = VERDICT_CRC;
		else
			code = VERDICT_OK;
	end

	// results of this byte, in order
	always_comb begin
		res1.kind    = KIND_VERDICT;
		res1.value   = 64'd0;
		res1.code    = code;
		res1.run_end = 1'b1;
		if (emit) begin
			res0.kind    = emit_kind;
			res0.value   = emit_value;
			res0.code    = VERDICT_OK;
			res0.run_end = !end_of_buffer;
		end else begin
			res0 = res1;
		end
	end

	assign push0 = accept && (emit || end_of_buffer);
	assign push1 = accept && emit && end_of_buffer;

	// packet state; a verdict returns it to the start of a packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			shift_q   <= 64'd0;
			crc_q     <= CRC_INIT;
			csum_q    <= 32'd0;
			blk_cnt_q <= 16'd0;
			pay_len_q <= 16'd0;
			ver_q     <= 8'd0;
			fault_q   <= FAULT_NONE;
		end else if (accept) begin
			if (end_of_buffer) begin
				pos_q     <= '0;
				shift_q   <= 64'd0;
				crc_q     <= CRC_INIT;
				csum_q    <= 32'd0;
				blk_cnt_q <= 16'd0;
				pay_len_q <= 16'd0;
				ver_q     <= 8'd0;
				fault_q   <= FAULT_NONE;
			end else begin
				pos_q     <= pos_next;
				shift_q   <= shift_next;
				crc_q     <= crc_next;
				csum_q    <= csum_next;
				blk_cnt_q <= blk_cnt_next;
				pay_len_q <= pay_len_next;
				ver_q     <= ver_next;
				fault_q   <= fault_next;
			end
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) begin
			if (push0 && wr_ptr_q == QPTR_W'(i))
				queue_q[i] <= res0;
			else if (push1 && (wr_ptr_q + QPTR_W'(1)) == QPTR_W'(i))
				queue_q[i] <= res1;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push0) + QPTR_W'(push1);
			rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
			count_q  <= count_q + QCNT_W'(push0) + QCNT_W'(push1) - QCNT_W'(pop);
		end
	end

	assign item_kind    = queue_q[rd_ptr_q].kind;
	assign item_value   = queue_q[rd_ptr_q].value;
	assign verdict_code = queue_q[rd_ptr_q].code;
	assign run_end      = queue_q[rd_ptr_q].run_end;

endmodule
`default_nettype wire
